// ===== rtl/vmex_pkg.sv =====
// ----------------------------------------------------------------------------
// vmex_pkg
// shared types and constants of the instruction execute core
// ----------------------------------------------------------------------------
package vmex_pkg;

  localparam int unsigned MEM_BYTES             = 4096;
  localparam int unsigned MEM_AW                = $clog2(MEM_BYTES);
  localparam int unsigned FB_ROWS               = 32;
  localparam int unsigned FB_ROW_AW             = $clog2(FB_ROWS);
  localparam int unsigned FB_WIDTH              = 64;
  localparam int unsigned NUM_VREGS             = 16;
  localparam int unsigned VREG_AW               = $clog2(NUM_VREGS);
  localparam int unsigned STACK_DEPTH_DEFAULT   = 16;
  localparam int unsigned PROGRAM_START_DEFAULT = 512;
  localparam int unsigned FONT_BYTES            = 80;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_EXEC  = 2'd1,
    CMD_ROW   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // one micro-operation per controller state
  typedef enum logic [4:0] {
    UOP_CLEAR, UOP_IDLE, UOP_WRMEM, UOP_FETCH_HI, UOP_FETCH_LO, UOP_RD_X, UOP_RD_Y,
    UOP_RD_V0, UOP_EXEC, UOP_FLAG, UOP_DRAW_RD, UOP_DRAW_A, UOP_DRAW_B, UOP_DRAW_END,
    UOP_BCD, UOP_ST_RD, UOP_ST_WR, UOP_LD_RD, UOP_LD_WR, UOP_ROW, UOP_DONE
  } uop_e;

  // multi-cycle class of the decoded instruction
  typedef enum logic [2:0] {
    K_PLAIN, K_FLAG, K_DRAW, K_BCD, K_STORE, K_LOAD
  } kind_e;

  typedef struct packed {
    uop_e uop;
  } ctrl_t;

  typedef struct packed {
    logic  in_fire;
    cmd_e  in_cmd;
    kind_e kind;
    logic  n_zero;
    logic  loop_last;
    logic  clear_last;
    logic  out_free;
  } stat_t;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // memory contents after reset: glyphs at the bottom, zeros above
  function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] addr);
    logic [7:0] b;
    b = 8'd0;
    if (addr < MEM_AW'(FONT_BYTES)) begin
      b = FONT[addr[6:0]];
    end
    return b;
  endfunction

  // decimal digit sel (0 hundreds, 1 tens, 2 ones) of an 8-bit value
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [1:0]  hund;
    logic [7:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    logic [7:0]  d;
    if (v >= 8'd200) begin
      hund = 2'd2;
      rem  = v - 8'd200;
    end else if (v >= 8'd100) begin
      hund = 2'd1;
      rem  = v - 8'd100;
    end else begin
      hund = 2'd0;
      rem  = v;
    end
    // reciprocal multiply, exact for values below one hundred
    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
    ones = rem[6:0] - 7'(tens) * 7'd10;
    case (sel)
      2'd0:    d = 8'(hund);
      2'd1:    d = 8'(tens);
      default: d = 8'(ones[3:0]);
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/vmex_ram.sv =====
// ----------------------------------------------------------------------------
// vmex_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module vmex_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vmex_ctrl.sv =====
// ----------------------------------------------------------------------------
// vmex_ctrl
// sequencer that steps the datapath through one command
// ----------------------------------------------------------------------------
module vmex_ctrl import vmex_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  typedef enum logic [20:0] {
    S_CLEAR    = 21'h000001,
    S_IDLE     = 21'h000002,
    S_WRMEM    = 21'h000004,
    S_FETCH_HI = 21'h000008,
    S_FETCH_LO = 21'h000010,
    S_RD_X     = 21'h000020,
    S_RD_Y     = 21'h000040,
    S_RD_V0    = 21'h000080,
    S_EXEC     = 21'h000100,
    S_FLAG     = 21'h000200,
    S_DRAW_RD  = 21'h000400,
    S_DRAW_A   = 21'h000800,
    S_DRAW_B   = 21'h001000,
    S_DRAW_END = 21'h002000,
    S_BCD      = 21'h004000,
    S_ST_RD    = 21'h008000,
    S_ST_WR    = 21'h010000,
    S_LD_RD    = 21'h020000,
    S_LD_WR    = 21'h040000,
    S_ROW      = 21'h080000,
    S_DONE     = 21'h100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (stat_i.in_fire) begin
          case (stat_i.in_cmd)
            CMD_WRITE: state_d = S_WRMEM;
            CMD_EXEC:  state_d = S_FETCH_HI;
            CMD_ROW:   state_d = S_ROW;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_WRMEM:    state_d = S_DONE;
      S_FETCH_HI: state_d = S_FETCH_LO;
      S_FETCH_LO: state_d = S_RD_X;
      S_RD_X:     state_d = S_RD_Y;
      S_RD_Y:     state_d = S_RD_V0;
      S_RD_V0:    state_d = S_EXEC;
      S_EXEC: begin
        case (stat_i.kind)
          K_FLAG:  state_d = S_FLAG;
          K_DRAW:  state_d = stat_i.n_zero ? S_DRAW_END : S_DRAW_RD;
          K_BCD:   state_d = S_BCD;
          K_STORE: state_d = S_ST_RD;
          K_LOAD:  state_d = S_LD_RD;
          default: state_d = S_DONE;
        endcase
      end
      S_FLAG:     state_d = S_DONE;
      S_DRAW_RD:  state_d = S_DRAW_A;
      S_DRAW_A:   state_d = S_DRAW_B;
      S_DRAW_B:   state_d = stat_i.loop_last ? S_DRAW_END : S_DRAW_RD;
      S_DRAW_END: state_d = S_DONE;
      S_BCD: begin
        if (stat_i.loop_last) state_d = S_DONE;
      end
      S_ST_RD:    state_d = S_ST_WR;
      S_ST_WR:    state_d = stat_i.loop_last ? S_DONE : S_ST_RD;
      S_LD_RD:    state_d = S_LD_WR;
      S_LD_WR:    state_d = stat_i.loop_last ? S_DONE : S_LD_RD;
      S_ROW:      state_d = S_DONE;
      S_DONE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default:    state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    case (state_q)
      S_CLEAR:    ctrl_o.uop = UOP_CLEAR;
      S_IDLE:     ctrl_o.uop = UOP_IDLE;
      S_WRMEM:    ctrl_o.uop = UOP_WRMEM;
      S_FETCH_HI: ctrl_o.uop = UOP_FETCH_HI;
      S_FETCH_LO: ctrl_o.uop = UOP_FETCH_LO;
      S_RD_X:     ctrl_o.uop = UOP_RD_X;
      S_RD_Y:     ctrl_o.uop = UOP_RD_Y;
      S_RD_V0:    ctrl_o.uop = UOP_RD_V0;
      S_EXEC:     ctrl_o.uop = UOP_EXEC;
      S_FLAG:     ctrl_o.uop = UOP_FLAG;
      S_DRAW_RD:  ctrl_o.uop = UOP_DRAW_RD;
      S_DRAW_A:   ctrl_o.uop = UOP_DRAW_A;
      S_DRAW_B:   ctrl_o.uop = UOP_DRAW_B;
      S_DRAW_END: ctrl_o.uop = UOP_DRAW_END;
      S_BCD:      ctrl_o.uop = UOP_BCD;
      S_ST_RD:    ctrl_o.uop = UOP_ST_RD;
      S_ST_WR:    ctrl_o.uop = UOP_ST_WR;
      S_LD_RD:    ctrl_o.uop = UOP_LD_RD;
      S_LD_WR:    ctrl_o.uop = UOP_LD_WR;
      S_ROW:      ctrl_o.uop = UOP_ROW;
      S_DONE:     ctrl_o.uop = UOP_DONE;
      default:    ctrl_o.uop = UOP_CLEAR;
    endcase
  end

endmodule

// ===== rtl/vmex_dp.sv =====
// ----------------------------------------------------------------------------
// vmex_dp
// machine state, memories, instruction decode and result register
// ----------------------------------------------------------------------------
module vmex_dp import vmex_pkg::*; #(
  parameter int unsigned STACK_DEPTH   = STACK_DEPTH_DEFAULT,
  parameter int unsigned PROGRAM_START = PROGRAM_START_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  output stat_t               stat_o,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [MEM_AW-1:0]   address_i,
  input  logic [7:0]          data_i,
  input  logic [15:0]         key_state_i,
  input  logic [7:0]          random_byte_i,
  input  logic [4:0]          row_select_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [MEM_AW-1:0]   program_counter_o,
  output logic [15:0]         executed_opcode_o,
  output logic                display_changed_o,
  output logic                sound_active_o,
  output logic                unknown_opcode_o,
  output logic [FB_WIDTH-1:0] row_pixels_o
);

  localparam int unsigned SP_W = $clog2(STACK_DEPTH);
  localparam logic [MEM_AW-1:0] PC_RESET = MEM_AW'(PROGRAM_START);
  localparam logic [SP_W-1:0]   SP_TOP   = SP_W'(STACK_DEPTH - 1);

  // instruction groups and sub-codes
  localparam logic [3:0]  OP_SYS = 4'h0, OP_JP = 4'h1, OP_CALL = 4'h2, OP_SE_I = 4'h3;
  localparam logic [3:0]  OP_SNE_I = 4'h4, OP_SE_R = 4'h5, OP_LD_I = 4'h6, OP_ADD_I = 4'h7;
  localparam logic [3:0]  OP_ALU = 4'h8, OP_SNE_R = 4'h9, OP_LD_IDX = 4'hA;
  localparam logic [3:0]  OP_JP_V0 = 4'hB, OP_RND = 4'hC, OP_DRW = 4'hD, OP_KEY = 4'hE;
  localparam logic [3:0]  OP_MISC = 4'hF;
  localparam logic [11:0] SYS_CLS = 12'h0E0, SYS_RET = 12'h0EE;
  localparam logic [3:0]  ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3;
  localparam logic [3:0]  ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7;
  localparam logic [3:0]  ALU_SHL = 4'hE;
  localparam logic [7:0]  KEY_SKP = 8'h9E, KEY_SKNP = 8'hA1;
  localparam logic [7:0]  MISC_GET_DT = 8'h07, MISC_WAIT = 8'h0A, MISC_SET_DT = 8'h15;
  localparam logic [7:0]  MISC_SET_ST = 8'h18, MISC_ADD_I = 8'h1E, MISC_FONT = 8'h29;
  localparam logic [7:0]  MISC_BCD = 8'h33, MISC_STORE = 8'h55, MISC_LOAD = 8'h65;
  localparam logic [3:0]  VF = 4'hF;
  localparam logic [3:0]  BCD_LAST = 4'd2;

  uop_e uop;
  assign uop = ctrl_i.uop;

  // captured input item
  cmd_e              cmd_q;
  logic [MEM_AW-1:0] addr_q;
  logic [7:0]        data_q, rnd_q;
  logic [15:0]       key_q;
  logic [4:0]        rowsel_q;

  // machine state
  logic [MEM_AW-1:0] pc_q, pc_d, idx_q, idx_d;
  logic [SP_W-1:0]   sp_q, sp_d, sp_inc, sp_dec;
  logic [MEM_AW-1:0] stack_q [STACK_DEPTH];
  logic [7:0]        dt_q, dt_d, st_q, st_d;
  logic [NUM_VREGS-1:0] v_val_q, v_val_d;
  logic [FB_ROWS-1:0]   fb_val_q, fb_val_d;
  logic [MEM_AW-1:0] clr_q;

  // per-instruction working registers
  logic [7:0]  hi_q, vx_q, vy_q;
  logic [15:0] op_q;
  logic [3:0]  cnt_q, cnt_d;
  logic        flag_q, hit_q, hit_d, drawn_q, unk_q;
  logic        v_rdv_q, fb_rdv_q;
  logic [5:0]  col_q;
  logic [9:0]  arow_q;
  logic [FB_WIDTH-1:0] maskb_q;

  // result register
  logic                out_valid_q;
  logic [MEM_AW-1:0]   out_pc_q;
  logic [15:0]         out_op_q;
  logic                out_drawn_q, out_snd_q, out_unk_q;
  logic [FB_WIDTH-1:0] out_row_q;

  // memory ports
  logic              m_we, m_re;
  logic [MEM_AW-1:0] m_waddr, m_raddr;
  logic [7:0]        m_wdata, m_rdata;
  logic              v_we, v_re;
  logic [VREG_AW-1:0] v_waddr, v_raddr;
  logic [7:0]        v_wdata, v_rdata, v_rd;
  logic              fb_we, fb_re;
  logic [FB_ROW_AW-1:0] fb_waddr, fb_raddr;
  logic [FB_WIDTH-1:0]  fb_wdata, fb_rdata, frow;

  logic in_fire, out_free, do_out;
  assign in_ready_o = (uop == UOP_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign do_out     = (uop == UOP_DONE) & out_free;

  assign v_rd = v_rdv_q  ? v_rdata  : 8'd0;
  assign frow = fb_rdv_q ? fb_rdata : '0;

  // opcode fields
  logic [3:0]        op_x, op_y, op_n;
  logic [7:0]        op_nn;
  logic [MEM_AW-1:0] op_nnn, mem_off, idx_end;
  assign op_x    = op_q[11:8];
  assign op_y    = op_q[7:4];
  assign op_n    = op_q[3:0];
  assign op_nn   = op_q[7:0];
  assign op_nnn  = op_q[11:0];
  assign mem_off = idx_q + MEM_AW'(cnt_q);
  assign idx_end = idx_q + MEM_AW'(op_x) + MEM_AW'(1);

  assign sp_inc = (sp_q == SP_TOP) ? '0 : sp_q + SP_W'(1);
  assign sp_dec = (sp_q == '0) ? SP_TOP : sp_q - SP_W'(1);

  // sprite placement
  logic [15:0]  draw_base;
  logic [127:0] draw_shift;
  logic         a_ok, b_ok;
  logic [FB_WIDTH-1:0] maska;
  assign draw_base  = 16'(vx_q) + ((16'(vy_q) + 16'(cnt_q)) << 6);
  assign draw_shift = {m_rdata, 120'd0} >> col_q;
  assign maska      = draw_shift[127:64];
  assign a_ok       = arow_q < 10'(FB_ROWS);
  assign b_ok       = (arow_q + 10'd1) < 10'(FB_ROWS);

  // instruction decode
  kind_e             kind;
  logic [MEM_AW-1:0] ex_next;
  logic              ex_unk, ex_draw, ex_cls, ex_ret, ex_call;
  logic              ex_v_we, ex_flag, ex_idx_we, ex_dt_we, ex_st_we;
  logic [3:0]        ex_v_addr;
  logic [7:0]        ex_v_data;
  logic [MEM_AW-1:0] ex_idx_data;
  logic [8:0]        sum9;
  logic [MEM_AW:0]   sum13;
  logic              pressed;

  always_comb begin
    kind        = K_PLAIN;
    ex_next     = pc_q + MEM_AW'(2);
    ex_unk      = 1'b0;
    ex_draw     = 1'b0;
    ex_cls      = 1'b0;
    ex_ret      = 1'b0;
    ex_call     = 1'b0;
    ex_v_we     = 1'b0;
    ex_v_addr   = op_x;
    ex_v_data   = 8'd0;
    ex_flag     = 1'b0;
    ex_idx_we   = 1'b0;
    ex_idx_data = op_nnn;
    ex_dt_we    = 1'b0;
    ex_st_we    = 1'b0;
    sum9        = {1'b0, vx_q} + {1'b0, vy_q};
    sum13       = {1'b0, idx_q} + (MEM_AW + 1)'(vx_q);
    pressed     = key_q[vx_q[3:0]];
    case (op_q[15:12])
      OP_SYS: begin
        if (op_nnn == SYS_CLS) begin
          ex_cls  = 1'b1;
          ex_draw = 1'b1;
        end else if (op_nnn == SYS_RET) begin
          ex_ret  = 1'b1;
          ex_next = stack_q[sp_dec] + MEM_AW'(2);
        end else begin
          ex_unk = 1'b1;
        end
      end
      OP_JP: ex_next = op_nnn;
      OP_CALL: begin
        ex_call = 1'b1;
        ex_next = op_nnn;
      end
      OP_SE_I:  if (vx_q == op_nn) ex_next = pc_q + MEM_AW'(4);
      OP_SNE_I: if (vx_q != op_nn) ex_next = pc_q + MEM_AW'(4);
      OP_SE_R:  if (vx_q == vy_q)  ex_next = pc_q + MEM_AW'(4);
      OP_SNE_R: if (vx_q != vy_q)  ex_next = pc_q + MEM_AW'(4);
      OP_LD_I: begin
        ex_v_we   = 1'b1;
        ex_v_data = op_nn;
      end
      OP_ADD_I: begin
        ex_v_we   = 1'b1;
        ex_v_data = vx_q + op_nn;
      end
      OP_ALU: begin
        ex_v_we = 1'b1;
        case (op_n)
          ALU_MOV: ex_v_data = vy_q;
          ALU_OR:  ex_v_data = vx_q | vy_q;
          ALU_AND: ex_v_data = vx_q & vy_q;
          ALU_XOR: ex_v_data = vx_q ^ vy_q;
          ALU_ADD: begin
            ex_v_data = sum9[7:0];
            ex_flag   = sum9[8];
            kind      = K_FLAG;
          end
          ALU_SUB: begin
            ex_v_data = vx_q - vy_q;
            ex_flag   = vx_q >= vy_q;
            kind      = K_FLAG;
          end
          ALU_SHR: begin
            ex_v_data = vx_q >> 1;
            ex_flag   = vx_q[0];
            kind      = K_FLAG;
          end
          ALU_SUBN: begin
            ex_v_data = vy_q - vx_q;
            ex_flag   = vy_q >= vx_q;
            kind      = K_FLAG;
          end
          ALU_SHL: begin
            ex_v_data = vx_q << 1;
            ex_flag   = vx_q[7];
            kind      = K_FLAG;
          end
          default: begin
            ex_v_we = 1'b0;
            ex_unk  = 1'b1;
          end
        endcase
      end
      OP_LD_IDX: ex_idx_we = 1'b1;
      OP_JP_V0:  ex_next = op_nnn + MEM_AW'(v_rd);
      OP_RND: begin
        ex_v_we   = 1'b1;
        ex_v_data = op_nn & rnd_q;
      end
      OP_DRW: begin
        kind    = K_DRAW;
        ex_draw = 1'b1;
      end
      OP_KEY: begin
        if (op_nn == KEY_SKP) begin
          if (pressed) ex_next = pc_q + MEM_AW'(4);
        end else if (op_nn == KEY_SKNP) begin
          if (!pressed) ex_next = pc_q + MEM_AW'(4);
        end else begin
          ex_unk = 1'b1;
        end
      end
      OP_MISC: begin
        case (op_nn)
          MISC_GET_DT: begin
            ex_v_we   = 1'b1;
            ex_v_data = dt_q;
          end
          MISC_WAIT:   ex_unk = 1'b0;
          MISC_SET_DT: ex_dt_we = 1'b1;
          MISC_SET_ST: ex_st_we = 1'b1;
          MISC_ADD_I: begin
            ex_idx_we   = 1'b1;
            ex_idx_data = sum13[MEM_AW-1:0];
            ex_v_we     = 1'b1;
            ex_v_addr   = VF;
            ex_v_data   = 8'(sum13[MEM_AW]);
          end
          MISC_FONT: begin
            ex_idx_we   = 1'b1;
            ex_idx_data = (MEM_AW'(vx_q) << 2) + MEM_AW'(vx_q);
          end
          MISC_BCD:   kind = K_BCD;
          MISC_STORE: kind = K_STORE;
          MISC_LOAD:  kind = K_LOAD;
          default:    ex_unk = 1'b1;
        endcase
      end
      default: ex_unk = 1'b1;
    endcase
  end

  // loop end per instruction class
  logic loop_last;
  always_comb begin
    case (kind)
      K_DRAW:  loop_last = (cnt_q == op_n - 4'd1);
      K_BCD:   loop_last = (cnt_q == BCD_LAST);
      K_STORE: loop_last = (cnt_q == op_x);
      K_LOAD:  loop_last = (cnt_q == op_x);
      default: loop_last = 1'b0;
    endcase
  end

  assign stat_o.in_fire    = in_fire;
  assign stat_o.in_cmd     = cmd_e'(command_i);
  assign stat_o.kind       = kind;
  assign stat_o.n_zero     = (op_n == 4'd0);
  assign stat_o.loop_last  = loop_last;
  assign stat_o.clear_last = (clr_q == '1);
  assign stat_o.out_free   = out_free;

  // memory port steering
  always_comb begin
    m_we     = 1'b0;
    m_waddr  = mem_off;
    m_wdata  = 8'd0;
    m_re     = 1'b0;
    m_raddr  = mem_off;
    v_we     = 1'b0;
    v_waddr  = ex_v_addr;
    v_wdata  = ex_v_data;
    v_re     = 1'b0;
    v_raddr  = cnt_q;
    fb_we    = 1'b0;
    fb_waddr = arow_q[FB_ROW_AW-1:0];
    fb_wdata = frow ^ maska;
    fb_re    = 1'b0;
    fb_raddr = draw_base[6 +: FB_ROW_AW];
    case (uop)
      UOP_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_q;
        m_wdata = font_byte(clr_q);
      end
      UOP_WRMEM: begin
        m_we    = 1'b1;
        m_waddr = addr_q;
        m_wdata = data_q;
      end
      UOP_FETCH_HI: begin
        m_re    = 1'b1;
        m_raddr = pc_q;
      end
      UOP_FETCH_LO: begin
        m_re    = 1'b1;
        m_raddr = pc_q + MEM_AW'(1);
      end
      UOP_RD_X: begin
        v_re    = 1'b1;
        v_raddr = hi_q[3:0];
      end
      UOP_RD_Y: begin
        v_re    = 1'b1;
        v_raddr = op_y;
      end
      UOP_RD_V0: begin
        v_re    = 1'b1;
        v_raddr = '0;
      end
      UOP_EXEC: v_we = ex_v_we;
      UOP_FLAG: begin
        v_we    = 1'b1;
        v_waddr = VF;
        v_wdata = 8'(flag_q);
      end
      UOP_DRAW_RD: begin
        m_re  = 1'b1;
        fb_re = 1'b1;
      end
      UOP_DRAW_A: begin
        fb_we    = a_ok;
        fb_re    = 1'b1;
        fb_raddr = arow_q[FB_ROW_AW-1:0] + FB_ROW_AW'(1);
      end
      UOP_DRAW_B: begin
        fb_we    = b_ok;
        fb_waddr = arow_q[FB_ROW_AW-1:0] + FB_ROW_AW'(1);
        fb_wdata = frow ^ maskb_q;
      end
      UOP_DRAW_END: begin
        v_we    = 1'b1;
        v_waddr = VF;
        v_wdata = 8'(hit_q);
      end
      UOP_BCD: begin
        m_we    = 1'b1;
        m_wdata = bcd_digit(vx_q, cnt_q[1:0]);
      end
      UOP_ST_RD: v_re = 1'b1;
      UOP_ST_WR: begin
        m_we    = 1'b1;
        m_wdata = v_rd;
      end
      UOP_LD_RD: m_re = 1'b1;
      UOP_LD_WR: begin
        v_we    = 1'b1;
        v_waddr = cnt_q;
        v_wdata = m_rdata;
      end
      UOP_ROW: begin
        fb_re    = 1'b1;
        fb_raddr = rowsel_q;
      end
      default: m_we = 1'b0;
    endcase
  end

  // next state of the machine registers
  always_comb begin
    pc_d     = pc_q;
    idx_d    = idx_q;
    sp_d     = sp_q;
    dt_d     = dt_q;
    st_d     = st_q;
    cnt_d    = cnt_q;
    hit_d    = hit_q;
    v_val_d  = v_val_q;
    fb_val_d = fb_val_q;
    if (v_we) v_val_d[v_waddr] = 1'b1;
    if (fb_we) fb_val_d[fb_waddr] = 1'b1;
    case (uop)
      UOP_EXEC: begin
        pc_d  = ex_next;
        cnt_d = '0;
        hit_d = 1'b0;
        if (ex_idx_we) idx_d = ex_idx_data;
        if (ex_call) sp_d = sp_inc;
        if (ex_ret) sp_d = sp_dec;
        if (ex_cls) fb_val_d = '0;
        // timers tick after the instruction took effect
        dt_d = ex_dt_we ? vx_q : dt_q;
        st_d = ex_st_we ? vx_q : st_q;
        if (dt_d != 8'd0) dt_d = dt_d - 8'd1;
        if (st_d != 8'd0) st_d = st_d - 8'd1;
      end
      UOP_DRAW_A: hit_d = hit_q | (a_ok & |(frow & maska));
      UOP_DRAW_B: begin
        hit_d = hit_q | (b_ok & |(frow & maskb_q));
        cnt_d = cnt_q + 4'd1;
      end
      UOP_BCD: cnt_d = cnt_q + 4'd1;
      UOP_ST_WR, UOP_LD_WR: begin
        cnt_d = cnt_q + 4'd1;
        if (loop_last) idx_d = idx_end;
      end
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_RESET;
      idx_q       <= '0;
      sp_q        <= '0;
      dt_q        <= '0;
      st_q        <= '0;
      cnt_q       <= '0;
      clr_q       <= '0;
      v_val_q     <= '0;
      fb_val_q    <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < STACK_DEPTH; k++) stack_q[k] <= '0;
    end else begin
      pc_q     <= pc_d;
      idx_q    <= idx_d;
      sp_q     <= sp_d;
      dt_q     <= dt_d;
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      v_val_q  <= v_val_d;
      fb_val_q <= fb_val_d;
      if (uop == UOP_CLEAR) clr_q <= clr_q + MEM_AW'(1);
      if (uop == UOP_EXEC && ex_call) stack_q[sp_q] <= pc_q;
      if (do_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q    <= cmd_e'(command_i);
      addr_q   <= address_i;
      data_q   <= data_i;
      key_q    <= key_state_i;
      rnd_q    <= random_byte_i;
      rowsel_q <= row_select_i;
    end
    if (v_re) v_rdv_q <= v_val_q[v_raddr];
    if (fb_re) fb_rdv_q <= fb_val_q[fb_raddr];
    if (uop == UOP_FETCH_LO) hi_q <= m_rdata;
    if (uop == UOP_RD_X) op_q <= {hi_q, m_rdata};
    if (uop == UOP_RD_Y) vx_q <= v_rd;
    if (uop == UOP_RD_V0) vy_q <= v_rd;
    hit_q <= hit_d;
    if (uop == UOP_EXEC) begin
      flag_q  <= ex_flag;
      drawn_q <= ex_draw;
      unk_q   <= ex_unk;
    end
    if (uop == UOP_DRAW_RD) begin
      col_q  <= draw_base[5:0];
      arow_q <= draw_base[15:6];
    end
    if (uop == UOP_DRAW_A) maskb_q <= draw_shift[63:0];
    if (do_out) begin
      out_pc_q    <= pc_q;
      out_op_q    <= (cmd_q == CMD_EXEC) ? op_q : 16'd0;
      out_drawn_q <= (cmd_q == CMD_EXEC) & drawn_q;
      out_unk_q   <= (cmd_q == CMD_EXEC) & unk_q;
      out_snd_q   <= (st_q != 8'd0);
      out_row_q   <= (cmd_q == CMD_ROW) ? frow : '0;
    end
  end

  vmex_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .waddr_i(m_waddr),
    .wdata_i(m_wdata),
    .re_i   (m_re),
    .raddr_i(m_raddr),
    .rdata_o(m_rdata)
  );

  vmex_ram #(.WIDTH(8), .DEPTH(NUM_VREGS)) u_vregs (
    .clk_i  (clk_i),
    .we_i   (v_we),
    .waddr_i(v_waddr),
    .wdata_i(v_wdata),
    .re_i   (v_re),
    .raddr_i(v_raddr),
    .rdata_o(v_rdata)
  );

  vmex_ram #(.WIDTH(FB_WIDTH), .DEPTH(FB_ROWS)) u_frame (
    .clk_i  (clk_i),
    .we_i   (fb_we),
    .waddr_i(fb_waddr),
    .wdata_i(fb_wdata),
    .re_i   (fb_re),
    .raddr_i(fb_raddr),
    .rdata_o(fb_rdata)
  );

  assign out_valid_o       = out_valid_q;
  assign program_counter_o = out_pc_q;
  assign executed_opcode_o = out_op_q;
  assign display_changed_o = out_drawn_q;
  assign sound_active_o    = out_snd_q;
  assign unknown_opcode_o  = out_unk_q;
  assign row_pixels_o      = out_row_q;

endmodule

// ===== rtl/vm_instruction_execute_core_unit.sv =====
// ----------------------------------------------------------------------------
// vm_instruction_execute_core_unit
// steps: fetch, operand reads, execute, then VF for flag alu ops and draw; draw
//   updates up to two rows per sprite row, bcd a digit and save/load a reg per pass
// throughput: one command at a time, next accepted while a result waits
// reset: a sweep over all 4096 bytes loads font and zeros into memory, no transfer taken
// ----------------------------------------------------------------------------
module vm_instruction_execute_core_unit import vmex_pkg::*; #(
  parameter int unsigned STACK_DEPTH   = STACK_DEPTH_DEFAULT,
  parameter int unsigned PROGRAM_START = PROGRAM_START_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel, one transfer per command
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [MEM_AW-1:0]   address_i,
  input  logic [7:0]          data_i,
  input  logic [15:0]         key_state_i,
  input  logic [7:0]          random_byte_i,
  input  logic [4:0]          row_select_i,
  // result channel, one transfer per command
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [MEM_AW-1:0]   program_counter_o,
  output logic [15:0]         executed_opcode_o,
  output logic                display_changed_o,
  output logic                sound_active_o,
  output logic                unknown_opcode_o,
  output logic [FB_WIDTH-1:0] row_pixels_o
);

  // the sequencer issues one micro-op per cycle, the datapath reports
  // decode class and loop progress back
  ctrl_t ctrl;
  stat_t stat;

  vmex_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .ctrl_o(ctrl)
  );

  // memory, registers, stack, timers, frame buffer and result register;
  // every memory has a single port pair, so operand reads are serialized
  vmex_dp #(
    .STACK_DEPTH  (STACK_DEPTH),
    .PROGRAM_START(PROGRAM_START)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .address_i        (address_i),
    .data_i           (data_i),
    .key_state_i      (key_state_i),
    .random_byte_i    (random_byte_i),
    .row_select_i     (row_select_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .program_counter_o(program_counter_o),
    .executed_opcode_o(executed_opcode_o),
    .display_changed_o(display_changed_o),
    .sound_active_o   (sound_active_o),
    .unknown_opcode_o (unknown_opcode_o),
    .row_pixels_o     (row_pixels_o)
  );

endmodule

// ===== rtl/vmex_checker.sv =====
// ----------------------------------------------------------------------------
// vmex_checker
// port-level checks of the instruction execute core
// ----------------------------------------------------------------------------
module vmex_checker import vmex_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [1:0]          command_i,
  input logic [MEM_AW-1:0]   address_i,
  input logic [7:0]          data_i,
  input logic [15:0]         key_state_i,
  input logic [7:0]          random_byte_i,
  input logic [4:0]          row_select_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [MEM_AW-1:0]   program_counter_o,
  input logic [15:0]         executed_opcode_o,
  input logic                display_changed_o,
  input logic                sound_active_o,
  input logic                unknown_opcode_o,
  input logic [FB_WIDTH-1:0] row_pixels_o
);

  // nothing taken or offered while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !in_ready_o && !out_valid_o)
    else $error("transfer possible during reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(program_counter_o)
      && $stable(executed_opcode_o) && $stable(row_pixels_o))
    else $error("result changed while stalled");

  // one command in flight: no transfer right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second command taken back to back");

  // an unrecognized opcode never touches the display
  a_unknown_no_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unknown_opcode_o |-> !display_changed_o)
    else $error("unknown opcode reported a display change");

  // row data only comes with a row read, which carries no opcode
  a_row_no_opcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (row_pixels_o != '0) |-> executed_opcode_o == 16'd0)
    else $error("row data on an execute result");

endmodule

bind vm_instruction_execute_core_unit vmex_checker u_checker (.*);
